@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files of the serial gamepad reader.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/sgr_pkg.sv @@
// Package of the serial gamepad reader: opcodes, reset constants and result beat type.
// No dependencies.
`default_nettype none

package sgr_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam int DIV_WIDTH = 16;
  localparam int IDX_WIDTH = 3;
  localparam int MASK_OUT_WIDTH = 8;
  localparam logic [DIV_WIDTH-1:0] DIVIDER_RESET = 16'd100;

  typedef struct packed {
    logic                      latch_out;
    logic                      clock_out;
    logic [MASK_OUT_WIDTH-1:0] pressed_mask;
    logic [MASK_OUT_WIDTH-1:0] held_mask;
    logic                      press_event;
    logic                      selected_pressed;
    logic                      selected_held;
  } result_t;

endpackage

`default_nettype wire

@@ src/serial_gamepad_reader_unit.sv @@
// Top level of the serial gamepad reader: divider, latch/clock sequencer and press masks.
// Depends on sgr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Each input beat is handled in a single state update: a tick beat advances the divider and, on a
// divided tick, the latch/clock sequencer; a clear beat consumes the pending presses.
// One result beat is produced per accepted beat. A new beat is accepted every cycle
// while the skid register is empty: the skid register behind the output register keeps
// input accepted for one more beat while the output is stalled.
module serial_gamepad_reader_unit
  import sgr_pkg::*;
#(
  parameter int BUTTON_COUNT = 8
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_write_enable,
  input  wire [DIV_WIDTH-1:0]       cfg_write_data,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire                       opcode,
  input  wire                       data_bit,
  input  wire [IDX_WIDTH-1:0]       button_index,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      latch_out,
  output logic                      clock_out,
  output logic [MASK_OUT_WIDTH-1:0] pressed_mask,
  output logic [MASK_OUT_WIDTH-1:0] held_mask,
  output logic                      press_event,
  output logic                      selected_pressed,
  output logic                      selected_held
);

  localparam int PHASE_WIDTH = $clog2(BUTTON_COUNT + 2);
  localparam logic [PHASE_WIDTH-1:0] PHASE_LATCH = PHASE_WIDTH'(0);
  localparam logic [PHASE_WIDTH-1:0] PHASE_FIRST = PHASE_WIDTH'(1);
  localparam logic [PHASE_WIDTH-1:0] PHASE_CLOCK = PHASE_WIDTH'(2);
  localparam logic [PHASE_WIDTH-1:0] PHASE_LAST  = PHASE_WIDTH'(BUTTON_COUNT);

  logic [DIV_WIDTH-1:0]    tick_divider;
  logic [DIV_WIDTH-1:0]    divider_count, divider_count_next;
  logic [PHASE_WIDTH-1:0]  phase, phase_next;
  logic [BUTTON_COUNT-1:0] shift_reg, shift_reg_next;
  logic [BUTTON_COUNT-1:0] pending_press, pending_press_next;
  logic [BUTTON_COUNT-1:0] consumed_mask, consumed_mask_next;
  logic [BUTTON_COUNT-1:0] held_snapshot, held_snapshot_next;
  logic                    latch_level, latch_level_next;
  logic                    clock_level, clock_level_next;

  logic                    accept;
  logic                    event_flag;
  logic                    sampled;
  logic [BUTTON_COUNT-1:0] shift_sampled;
  logic [BUTTON_COUNT-1:0] pending_merged;
  logic [31:0]             pending_ext, held_ext;
  logic [7:0]              pending_low, held_low;
  result_t                 result, out_reg, skid;
  logic                    skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign shift_sampled = {shift_reg[BUTTON_COUNT-2:0], data_bit};

  always_comb begin
    divider_count_next = divider_count;
    phase_next         = phase;
    shift_reg_next     = shift_reg;
    pending_press_next = pending_press;
    consumed_mask_next = consumed_mask;
    held_snapshot_next = held_snapshot;
    latch_level_next   = latch_level;
    clock_level_next   = clock_level;
    event_flag         = 1'b0;
    sampled            = 1'b0;
    pending_merged     = pending_press | ~shift_sampled;
    if (opcode == OP_CLEAR) begin
      consumed_mask_next = consumed_mask | pending_press;
      held_snapshot_next = '0;
      pending_press_next = '0;
    end else if (divider_count < tick_divider) begin
      divider_count_next = divider_count + DIV_WIDTH'(1);
    end else begin
      divider_count_next = '0;
      if (phase == PHASE_LATCH) begin
        latch_level_next = 1'b1;
        phase_next       = PHASE_FIRST;
      end else if (phase == PHASE_FIRST) begin
        latch_level_next = 1'b0;
        shift_reg_next   = shift_sampled;
        phase_next       = PHASE_CLOCK;
      end else begin
        clock_level_next = ~clock_level;
        if (clock_level) begin
          latch_level_next = 1'b0;
          shift_reg_next   = shift_sampled;
          phase_next       = phase + PHASE_WIDTH'(1);
          sampled          = (phase == PHASE_LAST);
        end
      end
      if (sampled) begin
        held_snapshot_next = pending_merged;
        pending_press_next = pending_merged & ~consumed_mask;
        consumed_mask_next = consumed_mask & ~shift_sampled;
        shift_reg_next     = '0;
        phase_next         = PHASE_LATCH;
        event_flag         = |(pending_merged & ~consumed_mask);
      end
    end
  end

  always_comb begin
    pending_ext = 32'(pending_press_next);
    held_ext    = 32'(held_snapshot_next);
    pending_low = pending_ext[7:0];
    held_low    = held_ext[7:0];
    result.latch_out        = latch_level_next;
    result.clock_out        = clock_level_next;
    result.pressed_mask     = pending_low;
    result.held_mask        = held_low;
    result.press_event      = event_flag;
    result.selected_pressed = pending_low[button_index];
    result.selected_held    = held_low[button_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider  <= DIVIDER_RESET;
      divider_count <= '0;
      phase         <= '0;
      shift_reg     <= '0;
      pending_press <= '0;
      consumed_mask <= '0;
      held_snapshot <= '0;
      latch_level   <= 1'b0;
      clock_level   <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        tick_divider <= cfg_write_data;
      end
      if (accept) begin
        divider_count <= divider_count_next;
        phase         <= phase_next;
        shift_reg     <= shift_reg_next;
        pending_press <= pending_press_next;
        consumed_mask <= consumed_mask_next;
        held_snapshot <= held_snapshot_next;
        latch_level   <= latch_level_next;
        clock_level   <= clock_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (accept) begin
        out_reg <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

  assign latch_out        = out_reg.latch_out;
  assign clock_out        = out_reg.clock_out;
  assign pressed_mask     = out_reg.pressed_mask;
  assign held_mask        = out_reg.held_mask;
  assign press_event      = out_reg.press_event;
  assign selected_pressed = out_reg.selected_pressed;
  assign selected_held    = out_reg.selected_held;

  `ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_IMPLY(a_latch_in_first_phase, clk, rst, latch_level, phase == PHASE_FIRST)
  `ASSERT_IMPLY(a_clock_after_latch, clk, rst, clock_level, phase >= PHASE_CLOCK)
  `ASSERT_NEXT(a_clear_empties, clk, rst, accept && opcode == OP_CLEAR,
               pending_press == '0 && held_snapshot == '0)

endmodule

`default_nettype wire
